/* design/bce_pkg.sv */
`default_nettype none

package bce_pkg;

    // field widths
    localparam int POINT_W = 32;
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    localparam int CFG_W   = 2;

    // stream packing
    localparam int S_FIELDS_W = 4 * POINT_W + T_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((POINT_W + 7) / 8) * 8;

    // arithmetic widths
    localparam int SQ_W       = 2 * T_FRAC + 1;       // t*t, s*s, s*t (max 1.0 squared)
    localparam int W_W        = 3 * T_FRAC + 1;       // Bernstein weight, max 1.0 cubed
    localparam int LO_W       = (W_W + 1) / 2;        // low slice of a weight
    localparam int HI_W       = W_W - LO_W;           // high slice of a weight
    localparam int LO_PROD_W  = POINT_W + LO_W;
    localparam int HI_PROD_W  = POINT_W + HI_W;
    localparam int ACC_W      = HI_PROD_W + LO_W + 1;
    localparam int RND_SHIFT  = 3 * T_FRAC;
    localparam int RND_W      = ACC_W - RND_SHIFT;
    localparam int N_PTS      = 4;
    localparam int N_STG      = 8;

    localparam logic [T_W-1:0]          T_ONE   = T_W'(1) << T_FRAC;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

    // curve_degree codes
    localparam logic [CFG_W-1:0] DEG_QUAD  = 2'd2;
    localparam logic [CFG_W-1:0] DEG_CUBIC = 2'd3;

    typedef logic signed [POINT_W-1:0] point_t;
    typedef logic [N_PTS-1:0][W_W-1:0] weight_set_t;

    // load strobes for the two weight generator stages
    typedef struct packed {
        logic ld_sq;
        logic ld_wt;
    } bce_wgen_ctl_t;

endpackage

`default_nettype wire

/* design/bce_weights.sv */
`default_nettype none

module bce_weights (
    input  wire logic                   aclk,
    input  wire bce_pkg::bce_wgen_ctl_t ctl,
    input  wire logic [bce_pkg::T_W-1:0] t_in,
    input  wire logic [bce_pkg::T_W-1:0] s_in,
    input  wire logic                   cubic_in,
    output bce_pkg::weight_set_t        w_out
);
    import bce_pkg::*;

    logic [SQ_W-1:0] ss_reg, st_reg, tt_reg;
    logic [T_W-1:0]  s1_reg, t1_reg;
    logic            cubic1_reg;

    logic [W_W:0]    sss_prod, sst_prod, stt_prod, ttt_prod;
    weight_set_t     w_next, w_reg;

    // squares and cross product of s and t
    always_ff @(posedge aclk) begin
        if (ctl.ld_sq) begin
            ss_reg     <= SQ_W'(s_in) * SQ_W'(s_in);
            st_reg     <= SQ_W'(s_in) * SQ_W'(t_in);
            tt_reg     <= SQ_W'(t_in) * SQ_W'(t_in);
            s1_reg     <= s_in;
            t1_reg     <= t_in;
            cubic1_reg <= cubic_in;
        end
    end

    // cubic products, one multiply deep
    always_comb begin
        sss_prod = ss_reg * s1_reg;
        sst_prod = ss_reg * t1_reg;
        stt_prod = st_reg * t1_reg;
        ttt_prod = tt_reg * t1_reg;
    end

    // Bernstein weights; quadratic weights are scaled up by one t unit so that
    // both modes round at the same bit position
    always_comb begin
        if (cubic1_reg) begin
            w_next[0] = sss_prod[W_W-1:0];
            w_next[1] = W_W'(sst_prod + {sst_prod[W_W-1:0], 1'b0});
            w_next[2] = W_W'(stt_prod + {stt_prod[W_W-1:0], 1'b0});
            w_next[3] = ttt_prod[W_W-1:0];
        end else begin
            w_next[0] = {ss_reg, {T_FRAC{1'b0}}};
            w_next[1] = {st_reg[SQ_W-2:0], {(T_FRAC+1){1'b0}}};
            w_next[2] = {tt_reg, {T_FRAC{1'b0}}};
            w_next[3] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_wt) begin
            w_reg <= w_next;
        end
    end

    assign w_out = w_reg;

endmodule

`default_nettype wire

/* design/bezier_curve_evaluator.sv */
`default_nettype none

// Bezier curve evaluator, one coordinate per transaction.
// s_ channel: s_tdata carries four signed Q16.16 control values and an
// unsigned Q1.16 parameter t; t above 1.0 is treated as 1.0.
// m_ channel: m_tdata carries the curve value, signed Q16.16, rounded to
// nearest (ties toward plus infinity).
// cfg_wr_en/cfg_wr_data write curve_degree: 2 is quadratic (point d unused),
// any other value is cubic. Write it only while the pipeline is empty.
// Throughput: one transaction per cycle while m_tready is high, set by the
// eight-stage pipeline (clamp, squares, weights, partial products, terms,
// pair sums, sum, round). Each stage holds a valid bit and loads whenever
// it is empty or the stage after it moves, so bubbles are squeezed out;
// while m_tready is low the pipeline keeps filling and s_tready drops only
// once every stage is full. Reset (aresetn low, synchronous) empties the
// pipeline and sets the degree to cubic.
module bezier_curve_evaluator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bce_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // point_a, point_b, point_c, point_d, t_param, zero pad
    input  wire logic [bce_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // curve_value
    output logic [bce_pkg::M_DATA_W-1:0]       m_tdata
);
    import bce_pkg::*;

    logic [CFG_W-1:0] curve_degree_reg;

    logic [N_STG-1:0] vld_reg;
    logic [N_STG:0]   rdy;

    point_t           pt_in [N_PTS];
    logic [T_W-1:0]   t_raw;
    logic [T_W-1:0]   t_next;

    point_t           pt0_reg [N_PTS];
    point_t           pt1_reg [N_PTS];
    point_t           pt2_reg [N_PTS];
    logic [T_W-1:0]   t0_reg, s0_reg;
    logic             cubic0_reg;

    bce_wgen_ctl_t    wgen_ctl;
    weight_set_t      w_set;

    logic signed [LO_PROD_W-1:0] lo_next [N_PTS];
    logic signed [HI_PROD_W-1:0] hi_next [N_PTS];
    logic signed [LO_PROD_W-1:0] lo_reg  [N_PTS];
    logic signed [HI_PROD_W-1:0] hi_reg  [N_PTS];
    logic signed [ACC_W-1:0]     term_next [N_PTS];
    logic signed [ACC_W-1:0]     term_reg  [N_PTS];
    logic signed [ACC_W-1:0]     pair_reg  [2];
    logic signed [ACC_W-1:0]     sum_next, sum_reg;

    logic [RND_W-1:0]            rnd;
    logic [ACC_W-1:RND_SHIFT+POINT_W-1] rnd_top;
    point_t                      out_next, out_reg;

    // degree register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_degree_reg <= DEG_CUBIC;
        end else if (cfg_wr_en) begin
            curve_degree_reg <= cfg_wr_data;
        end
    end

    // per-stage ready: a stage loads when empty or when the next one moves
    always_comb begin
        rdy[N_STG] = m_tready;
        for (int k = N_STG - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // unpack input transaction and clamp t to 1.0
    always_comb begin
        for (int i = 0; i < N_PTS; i++) begin
            pt_in[i] = s_tdata[i*POINT_W +: POINT_W];
        end
        t_raw  = s_tdata[N_PTS*POINT_W +: T_W];
        t_next = (t_raw > T_ONE) ? T_ONE : t_raw;
    end

    // stage 0: input register
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            pt0_reg    <= pt_in;
            t0_reg     <= t_next;
            s0_reg     <= T_ONE - t_next;
            cubic0_reg <= (curve_degree_reg != DEG_QUAD);
        end
    end

    // stages 1 and 2: Bernstein weights, points ride alongside
    assign wgen_ctl.ld_sq = rdy[1];
    assign wgen_ctl.ld_wt = rdy[2];

    bce_weights u_weights (
        .aclk     (aclk),
        .ctl      (wgen_ctl),
        .t_in     (t0_reg),
        .s_in     (s0_reg),
        .cubic_in (cubic0_reg),
        .w_out    (w_set)
    );

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            pt1_reg <= pt0_reg;
        end
        if (rdy[2]) begin
            pt2_reg <= pt1_reg;
        end
    end

    // stage 3: each point times the low and high slice of its weight
    always_comb begin
        for (int i = 0; i < N_PTS; i++) begin
            lo_next[i] = pt2_reg[i] * $signed({1'b0, w_set[i][LO_W-1:0]});
            hi_next[i] = pt2_reg[i] * $signed({1'b0, w_set[i][W_W-1:LO_W]});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // stage 4: recombine slices into full terms
    always_comb begin
        for (int i = 0; i < N_PTS; i++) begin
            term_next[i] = $signed({hi_reg[i][HI_PROD_W-1], hi_reg[i], {LO_W{1'b0}}})
                + $signed({{(ACC_W-LO_PROD_W){lo_reg[i][LO_PROD_W-1]}}, lo_reg[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            term_reg <= term_next;
        end
    end

    // stage 5: pair sums
    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            pair_reg[0] <= term_reg[0] + term_reg[1];
            pair_reg[1] <= term_reg[2] + term_reg[3];
        end
    end

    // stage 6: full sum plus rounding half
    assign sum_next = pair_reg[0] + pair_reg[1] + RND_HALF;

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            sum_reg <= sum_next;
        end
    end

    // stage 7: drop fraction bits and saturate
    always_comb begin
        rnd     = sum_reg[ACC_W-1:RND_SHIFT];
        rnd_top = sum_reg[ACC_W-1:RND_SHIFT+POINT_W-1];
        if ((&rnd_top) || !(|rnd_top)) begin
            out_next = rnd[POINT_W-1:0];
        end else if (rnd[RND_W-1]) begin
            out_next = POINT_MIN;
        end else begin
            out_next = POINT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[N_STG-1];
    assign m_tdata  = M_DATA_W'(out_reg);

    // a receiver that is ready never stalls the sender
    a_no_stall_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // weights of a valid item always add up to exactly one
    a_weights_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> ((W_W+2)'(w_set[0]) + (W_W+2)'(w_set[1]) + (W_W+2)'(w_set[2])
                        + (W_W+2)'(w_set[3])) == ((W_W+2)'(1) << RND_SHIFT))
        else $error("Bernstein weights do not sum to one");

    // a convex combination never needs saturation
    a_sum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[6] |-> ((&sum_reg[ACC_W-1:RND_SHIFT+POINT_W-1])
                        || !(|sum_reg[ACC_W-1:RND_SHIFT+POINT_W-1])))
        else $error("curve sum outside point range");

    // a result advances to the output only when a stage below holds one
    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) && !vld_reg[N_STG-2] |=> !m_tvalid)
        else $error("output valid without source");

endmodule

`default_nettype wire
